// ===== rtl/credit_aging_slot_table_assert.svh =====
// ----------------------------------------------------------------------------
// Credit aging slot table assertion macros
// Shared concurrent assertion forms for the slot table RTL.
// ----------------------------------------------------------------------------
`ifndef CREDIT_AGING_SLOT_TABLE_ASSERT_SVH
`define CREDIT_AGING_SLOT_TABLE_ASSERT_SVH

// Generic form with explicit clock and active-low reset.
`define CAT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("credit aging slot table check failed");

// Form for modules clocked by clk_i and reset by rst_ni.
`define CAT_ASSERT_CLK(lbl, prop) \
  `CAT_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ===== rtl/cat_pkg.sv =====
// ----------------------------------------------------------------------------
// Credit aging slot table package
// Shared constants, codes and control types.
// ----------------------------------------------------------------------------
package cat_pkg;

  localparam int unsigned ENTRIES_DEF     = 16;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned CREDIT_BITS_DEF = 16;

  localparam int unsigned CFG_W    = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [CFG_W-1:0] INIT_CREDIT_RST = 16'd20;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACCESS  = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_FLUSH   = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 3'd0,
    ST_INS_FREE  = 3'd1,
    ST_INS_REPL  = 3'd2,
    ST_LOAD_FAIL = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FLUSHED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RESOLVE,
    S_INSERT,
    S_AGE,
    S_REPORT
  } fsm_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic age;
    logic resolve;
    logic insert;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic plan_insert;
    logic plan_age;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/cat_item_if.sv =====
// ----------------------------------------------------------------------------
// Slot table request channel
// Valid/ready channel carrying one table transaction.
// ----------------------------------------------------------------------------
interface cat_item_if #(
  parameter int unsigned KEY_BITS = cat_pkg::KEY_BITS_DEF
) ();

  logic                        valid;
  logic                        ready;
  logic [cat_pkg::MODE_W-1:0]  mode;
  logic [KEY_BITS-1:0]         key;
  logic                        load_ok;

  modport source (output valid, mode, key, load_ok, input ready);
  modport sink   (input valid, mode, key, load_ok, output ready);

endinterface

// ===== rtl/cat_result_if.sv =====
// ----------------------------------------------------------------------------
// Slot table result channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface cat_result_if #(
  parameter int unsigned ENTRIES  = cat_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = cat_pkg::KEY_BITS_DEF
) ();

  localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);

  logic                          valid;
  logic                          ready;
  logic [cat_pkg::STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]             slot;
  logic [KEY_BITS-1:0]           replaced_key;
  logic [ENTRIES-1:0]            evicted_mask;
  logic [CNT_W-1:0]              valid_count;

  modport source (output valid, status, slot, replaced_key, evicted_mask, valid_count,
                  input ready);
  modport sink   (input valid, status, slot, replaced_key, evicted_mask, valid_count,
                  output ready);

endinterface

// ===== rtl/credit_aging_slot_table.sv =====
// ----------------------------------------------------------------------------
// Credit aging slot table
// Fully associative key table with credit aging, release and flush.
// ----------------------------------------------------------------------------
// One transaction at a time: each access request walks the table twice,
// one entry per cycle through the key and credit memories (search, then
// aging); release, flush, failed loads and unused modes skip the aging
// walk. The result sits in an output register, so the next request is
// taken while it waits.
module credit_aging_slot_table #(
  parameter int unsigned ENTRIES     = cat_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = cat_pkg::KEY_BITS_DEF,
  parameter int unsigned CREDIT_BITS = cat_pkg::CREDIT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cat_pkg::CFG_W-1:0] cfg_wdata_i,
  cat_item_if.sink                  item_i,
  cat_result_if.source              result_o
);

  cat_pkg::ctrl_cmd_t cmd;
  cat_pkg::dp_stat_t  stat;

  cat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  cat_dpath #(
    .ENTRIES     (ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .CREDIT_BITS (CREDIT_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .result_o    (result_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== rtl/cat_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot table controller
// Sequences search, resolve, insert, aging and result hand-off.
// ----------------------------------------------------------------------------
module cat_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  cat_item_if.sink           item_i,
  input  cat_pkg::dp_stat_t  stat_i,
  output cat_pkg::ctrl_cmd_t cmd_o
);

  cat_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cat_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    item_i.ready = 1'b0;
    unique case (state_q)
      cat_pkg::S_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid) begin
          cmd_o.load = 1'b1;
          state_d    = cat_pkg::S_SEARCH;
        end
      end
      cat_pkg::S_SEARCH: begin
        cmd_o.scan = 1'b1;
        if (stat_i.walk_done) begin
          state_d = cat_pkg::S_RESOLVE;
        end
      end
      cat_pkg::S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        if (stat_i.plan_insert) begin
          state_d = cat_pkg::S_INSERT;
        end else if (stat_i.plan_age) begin
          state_d = cat_pkg::S_AGE;
        end else begin
          state_d = cat_pkg::S_REPORT;
        end
      end
      cat_pkg::S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = cat_pkg::S_AGE;
      end
      cat_pkg::S_AGE: begin
        cmd_o.scan = 1'b1;
        cmd_o.age  = 1'b1;
        if (stat_i.walk_done) begin
          state_d = cat_pkg::S_REPORT;
        end
      end
      cat_pkg::S_REPORT: begin
        if (!stat_i.out_busy) begin
          cmd_o.report = 1'b1;
          state_d      = cat_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cat_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/cat_dpath.sv =====
// ----------------------------------------------------------------------------
// Slot table datapath
// Key and credit memories, valid bits, entry walk, aging and result register.
// ----------------------------------------------------------------------------
`include "credit_aging_slot_table_assert.svh"

module cat_dpath #(
  parameter int unsigned ENTRIES     = cat_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS    = cat_pkg::KEY_BITS_DEF,
  parameter int unsigned CREDIT_BITS = cat_pkg::CREDIT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cat_pkg::CFG_W-1:0] cfg_wdata_i,
  cat_item_if.sink                  item_i,
  cat_result_if.source              result_o,
  input  cat_pkg::ctrl_cmd_t        cmd_i,
  output cat_pkg::dp_stat_t         stat_o
);

  localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned WIDE_W = cat_pkg::CFG_W + CREDIT_BITS;
  localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = {CREDIT_BITS{1'b1}};

  function automatic logic [CNT_W-1:0] popcount(input logic [ENTRIES-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  logic [cat_pkg::CFG_W-1:0]  init_credit_q;
  logic [cat_pkg::MODE_W-1:0] mode_q;
  logic [KEY_BITS-1:0]        key_q;
  logic                       load_ok_q;

  logic [KEY_BITS-1:0]    key_mem    [ENTRIES];
  logic [CREDIT_BITS-1:0] credit_mem [ENTRIES];
  logic [KEY_BITS-1:0]    rd_key_q;
  logic [CREDIT_BITS-1:0] rd_credit_q;

  logic [CNT_W-1:0]  cnt_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic [ENTRIES-1:0] valid_q;

  logic                   found_q;
  logic [SLOT_W-1:0]      found_idx_q;
  logic [SLOT_W-1:0]      min_idx_q;
  logic [CREDIT_BITS-1:0] min_credit_q;
  logic [KEY_BITS-1:0]    min_key_q;

  cat_pkg::status_e   status_q, status_d;
  logic [SLOT_W-1:0]  use_q, use_d;
  logic [KEY_BITS-1:0] rkey_q, rkey_d;
  logic [CNT_W-1:0]   others_q, others_d;
  logic [ENTRIES-1:0] mask_q;

  logic               out_valid_q;
  cat_pkg::status_e   out_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [KEY_BITS-1:0] out_rkey_q;
  logic [ENTRIES-1:0] out_mask_q;
  logic [CNT_W-1:0]   out_count_q;

  logic                   issue;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   rd_ent_valid;
  logic                   srch;
  logic                   age_act;
  logic [CREDIT_BITS-1:0] dec_credit;
  logic [CREDIT_BITS:0]   used_sum;
  logic [CREDIT_BITS-1:0] used_credit;
  logic [CREDIT_BITS-1:0] new_credit;
  logic                   evict;
  logic [WIDE_W-1:0]      init_wide;
  logic [CREDIT_BITS-1:0] init_sat;
  logic                   cr_we;
  logic [SLOT_W-1:0]      cr_waddr;
  logic [CREDIT_BITS-1:0] cr_wdata;
  logic                   free_any;
  logic [SLOT_W-1:0]      free_idx;
  logic [CNT_W-1:0]       popcnt;
  logic                   p_insert, p_age, p_release, p_flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_credit_q <= cat_pkg::INIT_CREDIT_RST;
    end else if (cfg_we_i) begin
      init_credit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= item_i.mode;
      key_q     <= item_i.key;
      load_ok_q <= item_i.load_ok;
    end
  end

  assign issue        = cmd_i.scan && (cnt_q < CNT_W'(ENTRIES));
  assign rd_addr      = cnt_q[SLOT_W-1:0];
  assign rd_ent_valid = valid_q[rd_idx_q];
  assign srch         = rd_vld_q && !cmd_i.age;
  assign age_act      = rd_vld_q && cmd_i.age && rd_ent_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.load || cmd_i.resolve) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= rd_addr;
    end
  end

  // Key memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      key_mem[use_q] <= key_q;
    end
    if (issue) begin
      rd_key_q <= key_mem[rd_addr];
    end
  end

  // Credit memory
  always_ff @(posedge clk_i) begin
    if (cr_we) begin
      credit_mem[cr_waddr] <= cr_wdata;
    end
    if (issue) begin
      rd_credit_q <= credit_mem[rd_addr];
    end
  end

  assign init_wide = WIDE_W'(init_credit_q);
  assign init_sat  = (init_wide > WIDE_W'(CREDIT_MAX)) ? CREDIT_MAX
                                                       : init_wide[CREDIT_BITS-1:0];

  assign dec_credit  = (rd_credit_q == '0) ? '0 : rd_credit_q - CREDIT_BITS'(1);
  assign used_sum    = {1'b0, dec_credit} + (CREDIT_BITS + 1)'(others_q);
  assign used_credit = used_sum[CREDIT_BITS] ? CREDIT_MAX : used_sum[CREDIT_BITS-1:0];
  assign new_credit  = (rd_idx_q == use_q) ? used_credit : dec_credit;
  assign evict       = age_act && (new_credit == '0);

  assign cr_we    = cmd_i.insert || age_act;
  assign cr_waddr = cmd_i.insert ? use_q : rd_idx_q;
  assign cr_wdata = cmd_i.insert ? init_sat : new_credit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (srch && rd_ent_valid && (rd_key_q == key_q) && !found_q) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (srch && rd_ent_valid && (rd_key_q == key_q) && !found_q) begin
      found_idx_q <= rd_idx_q;
    end
    if (srch && ((rd_idx_q == '0) || (rd_credit_q < min_credit_q))) begin
      min_idx_q    <= rd_idx_q;
      min_credit_q <= rd_credit_q;
      min_key_q    <= rd_key_q;
    end
  end

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign popcnt = popcount(valid_q);

  always_comb begin
    status_d  = cat_pkg::ST_NOT_FOUND;
    use_d     = '0;
    rkey_d    = '0;
    others_d  = popcnt;
    p_insert  = 1'b0;
    p_age     = 1'b0;
    p_release = 1'b0;
    p_flush   = 1'b0;
    unique case (mode_q)
      cat_pkg::MODE_ACCESS: begin
        if (found_q) begin
          status_d = cat_pkg::ST_HIT;
          use_d    = found_idx_q;
          others_d = popcnt - CNT_W'(1);
          p_age    = 1'b1;
        end else if (!load_ok_q) begin
          status_d = cat_pkg::ST_LOAD_FAIL;
        end else if (free_any) begin
          status_d = cat_pkg::ST_INS_FREE;
          use_d    = free_idx;
          p_insert = 1'b1;
          p_age    = 1'b1;
        end else begin
          status_d = cat_pkg::ST_INS_REPL;
          use_d    = min_idx_q;
          rkey_d   = min_key_q;
          others_d = popcnt - CNT_W'(1);
          p_insert = 1'b1;
          p_age    = 1'b1;
        end
      end
      cat_pkg::MODE_RELEASE: begin
        if (found_q) begin
          status_d  = cat_pkg::ST_RELEASED;
          use_d     = found_idx_q;
          p_release = 1'b1;
        end
      end
      cat_pkg::MODE_FLUSH: begin
        status_d = cat_pkg::ST_FLUSHED;
        p_flush  = 1'b1;
      end
      default: begin
        status_d = cat_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      status_q <= status_d;
      use_q    <= use_d;
      rkey_q   <= rkey_d;
      others_q <= others_d;
      mask_q   <= p_flush ? valid_q : '0;
    end else if (evict) begin
      mask_q[rd_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.resolve && p_release) begin
        valid_q[found_idx_q] <= 1'b0;
      end
      if (cmd_i.resolve && p_flush) begin
        valid_q <= '0;
      end
      if (cmd_i.insert) begin
        valid_q[use_q] <= 1'b1;
      end
      if (evict) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.report) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      out_status_q <= status_q;
      out_slot_q   <= use_q;
      out_rkey_q   <= rkey_q;
      out_mask_q   <= mask_q;
      out_count_q  <= popcnt;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_status_q;
  assign result_o.slot         = out_slot_q;
  assign result_o.replaced_key = out_rkey_q;
  assign result_o.evicted_mask = out_mask_q;
  assign result_o.valid_count  = out_count_q;

  assign stat_o.walk_done   = rd_vld_q && (rd_idx_q == SLOT_W'(ENTRIES - 1));
  assign stat_o.plan_insert = p_insert;
  assign stat_o.plan_age    = p_age;
  assign stat_o.out_busy    = out_valid_q && !result_o.ready;

  `CAT_ASSERT_CLK(a_rd_idx_range, rd_vld_q |-> (rd_idx_q <= SLOT_W'(ENTRIES - 1)))
  `CAT_ASSERT_CLK(a_insert_sets_valid, cmd_i.insert |=> valid_q[use_q])
  `CAT_ASSERT_CLK(a_repl_only_full, (cmd_i.resolve && (status_d == cat_pkg::ST_INS_REPL)) |-> (&valid_q))
  `CAT_ASSERT_CLK(a_flush_empties, (result_o.valid && (result_o.status == cat_pkg::ST_FLUSHED)) |-> (result_o.valid_count == '0))

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Credit aging slot table testbench
// Drives access, release, flush and unused-mode transactions through the
// request channel under random idling on both sides. The scoreboard predicts
// each result from its own copy of the slot table and checks every result
// field by field. Several initial credit settings are covered.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SLOTS          = cat_pkg::ENTRIES_DEF;
  localparam int unsigned KEY_W          = cat_pkg::KEY_BITS_DEF;
  localparam int unsigned CREDIT_W       = cat_pkg::CREDIT_BITS_DEF;
  localparam int unsigned SLOT_W         = $clog2(SLOTS);
  localparam int unsigned COUNT_W        = $clog2(SLOTS + 1);
  localparam int unsigned CREDIT_MAX     = (1 << CREDIT_W) - 1;
  localparam int unsigned POOL_SIZE      = 24;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 2 * SLOTS + 16;
  localparam int unsigned MAX_REPORTS    = 100;

  localparam logic [cat_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [cat_pkg::MODE_W-1:0] mode;
    logic [KEY_W-1:0]           key;
    logic                       load_ok;
  } request_t;

  typedef struct packed {
    cat_pkg::status_e   status;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   replaced_key;
    logic [SLOTS-1:0]   evicted_mask;
    logic [COUNT_W-1:0] valid_count;
  } outcome_t;

  class slot_table_scoreboard;
    bit                        slot_live [SLOTS];
    bit [KEY_W-1:0]            slot_key [SLOTS];
    bit [CREDIT_W-1:0]         slot_credit [SLOTS];
    bit [cat_pkg::CFG_W-1:0]   start_credit = cat_pkg::INIT_CREDIT_RST;
    outcome_t                  pending_outcomes [$];
    int unsigned               mismatch_count;
    int unsigned               results_seen;

    function logic [SLOTS-1:0] age_from(int unsigned used);
      int unsigned      others;
      int unsigned      sum;
      logic [SLOTS-1:0] gone;
      int               i;
      others = 0;
      gone   = '0;
      sum    = (slot_credit[used] != 0) ? slot_credit[used] - 1 : 0;
      for (i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && i != used) begin
          if (slot_credit[i] != 0) slot_credit[i]--;
          others++;
        end
      end
      sum += others;
      slot_credit[used] = (sum > CREDIT_MAX) ? CREDIT_MAX[CREDIT_W-1:0] : CREDIT_W'(sum);
      for (i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && slot_credit[i] == 0) begin
          slot_live[i] = 1'b0;
          gone[i]      = 1'b1;
        end
      end
      return gone;
    endfunction

    function outcome_t predict_outcome(request_t req);
      outcome_t    o;
      int          found;
      int          pick;
      int unsigned live_total;
      int          i;
      o        = '0;
      o.status = cat_pkg::ST_NOT_FOUND;
      found    = -1;
      if (req.mode == cat_pkg::MODE_ACCESS || req.mode == cat_pkg::MODE_RELEASE) begin
        for (i = 0; i < SLOTS; i++) begin
          if (found < 0 && slot_live[i] && slot_key[i] == req.key) found = i;
        end
      end
      if (req.mode == cat_pkg::MODE_ACCESS) begin
        pick = found;
        if (found >= 0) begin
          o.status = cat_pkg::ST_HIT;
        end else if (!req.load_ok) begin
          o.status = cat_pkg::ST_LOAD_FAIL;
        end else begin
          for (i = 0; i < SLOTS; i++) begin
            if (pick < 0 && !slot_live[i]) pick = i;
          end
          if (pick >= 0) begin
            o.status = cat_pkg::ST_INS_FREE;
          end else begin
            pick = 0;
            for (i = 1; i < SLOTS; i++) begin
              if (slot_credit[i] < slot_credit[pick]) pick = i;
            end
            o.status       = cat_pkg::ST_INS_REPL;
            o.replaced_key = slot_key[pick];
          end
          slot_live[pick]   = 1'b1;
          slot_key[pick]    = req.key;
          slot_credit[pick] = start_credit;
        end
        if (o.status != cat_pkg::ST_LOAD_FAIL) begin
          o.slot         = SLOT_W'(pick);
          o.evicted_mask = age_from(pick);
        end
      end else if (req.mode == cat_pkg::MODE_RELEASE) begin
        if (found >= 0) begin
          slot_live[found]   = 1'b0;
          slot_credit[found] = '0;
          o.status           = cat_pkg::ST_RELEASED;
          o.slot             = SLOT_W'(found);
        end
      end else if (req.mode == cat_pkg::MODE_FLUSH) begin
        for (i = 0; i < SLOTS; i++) begin
          o.evicted_mask[i] = slot_live[i];
          slot_live[i]      = 1'b0;
          slot_credit[i]    = '0;
        end
        o.status = cat_pkg::ST_FLUSHED;
      end
      live_total = 0;
      for (i = 0; i < SLOTS; i++) begin
        if (slot_live[i]) live_total++;
      end
      o.valid_count = COUNT_W'(live_total);
      return o;
    endfunction

    function void note_request(request_t req);
      pending_outcomes.push_back(predict_outcome(req));
    endfunction

    task report(string field, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("result %0d: %s is %0h, expected %0h", results_seen, field, got, want);
      end
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        report("unexpected transaction, status", KEY_W'(got.status), '0);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.status !== want.status) begin
        report("status", KEY_W'(got.status), KEY_W'(want.status));
      end
      if (got.slot !== want.slot) report("slot", KEY_W'(got.slot), KEY_W'(want.slot));
      if (got.replaced_key !== want.replaced_key) begin
        report("replaced_key", got.replaced_key, want.replaced_key);
      end
      if (got.evicted_mask !== want.evicted_mask) begin
        report("evicted_mask", KEY_W'(got.evicted_mask), KEY_W'(want.evicted_mask));
      end
      if (got.valid_count !== want.valid_count) begin
        report("valid_count", KEY_W'(got.valid_count), KEY_W'(want.valid_count));
      end
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [cat_pkg::CFG_W-1:0] cfg_wdata_i;

  cat_item_if   item_bus ();
  cat_result_if result_bus ();

  slot_table_scoreboard sb;
  logic [KEY_W-1:0]     key_pool [POOL_SIZE];
  int unsigned          send_calm;

  credit_aging_slot_table i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned draw_idle(ref int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic void refill_key_pool();
    logic [KEY_W-1:0] base;
    int               i;
    base = $urandom();
    for (i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) key_pool[i] = $urandom();
      else key_pool[i] = base ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
    end
  endfunction

  function automatic request_t random_request();
    request_t    req;
    int unsigned roll;
    roll        = $urandom_range(0, 99);
    req.key     = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    req.load_ok = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 19) == 0) req.key = $urandom();
    if (roll < 80) req.mode = cat_pkg::MODE_ACCESS;
    else if (roll < 94) req.mode = cat_pkg::MODE_RELEASE;
    else if (roll < 97) req.mode = cat_pkg::MODE_FLUSH;
    else req.mode = MODE_UNUSED;
    return req;
  endfunction

  task automatic offer_request(input logic [cat_pkg::MODE_W-1:0] mode,
                               input logic [KEY_W-1:0] key,
                               input logic load_ok);
    int unsigned gap;
    request_t    req;
    req.mode    = mode;
    req.key     = key;
    req.load_ok = load_ok;
    gap         = draw_idle(send_calm);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid   <= 1'b1;
    item_bus.mode    <= mode;
    item_bus.key     <= key;
    item_bus.load_ok <= load_ok;
    @(posedge clk_i);
    while (item_bus.ready !== 1'b1) @(posedge clk_i);
    sb.note_request(req);
  endtask

  task automatic write_start_credit(input logic [cat_pkg::CFG_W-1:0] value);
    item_bus.valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    sb.start_credit  = value;
  endtask

  initial begin : stimulus
    logic [cat_pkg::CFG_W-1:0] phase_credit [4];
    request_t                  req;
    int                        n;
    int                        p;
    sb = new;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    item_bus.valid   <= 1'b0;
    item_bus.mode    <= cat_pkg::MODE_ACCESS;
    item_bus.key     <= '0;
    item_bus.load_ok <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_start_credit(16'd1);
    offer_request(cat_pkg::MODE_RELEASE, '0, 1'b0);
    offer_request(cat_pkg::MODE_ACCESS, '0, 1'b0);
    offer_request(cat_pkg::MODE_ACCESS, '0, 1'b1);
    offer_request(MODE_UNUSED, '1, 1'b1);

    write_start_credit('1);
    for (n = 0; n < SLOTS; n++) begin
      offer_request(cat_pkg::MODE_ACCESS,
                    (n == 0) ? '1 : (n == 1) ? '0 : KEY_W'(32'h3C00_0000 | n), 1'b1);
    end
    offer_request(cat_pkg::MODE_ACCESS, 32'hA5A5_A5A5, 1'b1);
    offer_request(cat_pkg::MODE_ACCESS, '1, 1'b0);
    offer_request(cat_pkg::MODE_RELEASE, '0, 1'b1);
    offer_request(cat_pkg::MODE_FLUSH, '1, 1'b1);

    phase_credit[0] = 16'd1;
    phase_credit[1] = cat_pkg::INIT_CREDIT_RST;
    phase_credit[2] = '1;
    phase_credit[3] = cat_pkg::CFG_W'($urandom_range(2, 300));
    for (p = 0; p < 4; p++) begin
      write_start_credit(phase_credit[p]);
      refill_key_pool();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        req = random_request();
        offer_request(req.mode, req.key, req.load_ok);
      end
    end

    item_bus.valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending_outcomes.size() == 0) begin
      $display("** credit_aging_slot_table: PASSED **");
    end else begin
      $display("** credit_aging_slot_table: FAILED **");
    end
    $finish;
  end

  initial begin : result_sink
    outcome_t    got;
    int unsigned gap;
    int unsigned taken;
    int unsigned calm;
    taken = 0;
    calm  = 0;
    result_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = (taken == 100 || taken == 300) ? LONG_HOLD : draw_idle(calm);
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (result_bus.valid !== 1'b1) @(posedge clk_i);
      got.status       = cat_pkg::status_e'(result_bus.status);
      got.slot         = result_bus.slot;
      got.replaced_key = result_bus.replaced_key;
      got.evicted_mask = result_bus.evicted_mask;
      got.valid_count  = result_bus.valid_count;
      sb.check_result(got);
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
          (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** credit_aging_slot_table: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cat_pkg.sv
rtl/cat_item_if.sv
rtl/cat_result_if.sv
rtl/cat_ctrl.sv
rtl/cat_dpath.sv
rtl/credit_aging_slot_table.sv
bench/tb.sv
